// File: design/tss_pkg.sv
package tss_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_IMU_PRESENT    = 3'd0,
		REG_GYRO_LIMIT_SQ  = 3'd1,
		REG_ACCEL_LIMIT_SQ = 3'd2,
		REG_QUIET_MS       = 3'd3,
		REG_SETTLE_MS      = 3'd4,
		REG_SCAN_MS        = 3'd5,
		REG_TILT_LIMIT     = 3'd6,
		REG_REPORT_MS      = 3'd7
	} tss_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// sequencer states
	typedef enum logic [1:0] {
		MODE_MOVING = 2'd0,
		MODE_STAB   = 2'd1,
		MODE_SCAN   = 2'd2,
		MODE_DONE   = 2'd3
	} tss_mode_t;

	typedef struct packed {
		logic        imu_present;
		logic [31:0] gyro_limit_sq;
		logic [31:0] accel_limit_sq;
		logic [15:0] quiet_ms;
		logic [15:0] settle_ms;
		logic [31:0] scan_ms;
		logic [9:0]  tilt_limit_steps;
		logic [15:0] report_ms;
	} tss_cfg_t;

	typedef struct packed {
		logic [1:0]         scan_state;
		logic signed [10:0] target_steps;
		logic               step_run;
		logic               driver_disable;
		logic               base_moving;
		logic               report_due;
	} tss_result_t;

	localparam int RESULT_W = $bits(tss_result_t);

endpackage

// File: design/tss_fifo.sv
module tss_fifo
	import tss_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	// depth is a power of two so the pointers wrap on their own
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/tss_front.sv
module tss_front
	import tss_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tss_cfg_t             cfg,
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          now_ms,
	input  logic signed [15:0]   gyro_x,
	input  logic signed [15:0]   gyro_y,
	input  logic signed [15:0]   gyro_z,
	input  logic signed [15:0]   accel_x,
	input  logic signed [15:0]   accel_y,
	input  logic signed [15:0]   accel_z,
	input  logic                 at_target,
	output logic                 item_valid,
	input  logic                 item_ready,
	output logic [TIME_BITS+1:0] item_data
);

	function automatic logic [30:0] square16(input logic signed [15:0] v);
		logic signed [31:0] w;
		logic signed [31:0] p;
		w = 32'(v);
		p = w * w;
		return p[30:0];
	endfunction

	logic                 valid_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 at_target_s1;
	logic [30:0]          gx_sq_s1, gy_sq_s1, gz_sq_s1;
	logic [30:0]          ax_sq_s1, ay_sq_s1, az_sq_s1;
	logic [63:0]          now_wide;
	logic [31:0]          gyro_sum;
	logic [31:0]          accel_sum;
	logic                 motion;
	logic                 accept;

	assign now_wide = {32'd0, now_ms};
	assign full     = valid_s1 && !item_ready;
	assign accept   = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1       <= now_wide[TIME_BITS-1:0];
			at_target_s1 <= at_target;
			gx_sq_s1     <= square16(gyro_x);
			gy_sq_s1     <= square16(gyro_y);
			gz_sq_s1     <= square16(gyro_z);
			ax_sq_s1     <= square16(accel_x);
			ay_sq_s1     <= square16(accel_y);
			az_sq_s1     <= square16(accel_z);
		end
	end

	// sums stay at or below 3*2^30
	assign gyro_sum  = 32'(gx_sq_s1) + 32'(gy_sq_s1) + 32'(gz_sq_s1);
	assign accel_sum = 32'(ax_sq_s1) + 32'(ay_sq_s1) + 32'(az_sq_s1);
	assign motion    = cfg.imu_present &&
		((gyro_sum > cfg.gyro_limit_sq) || (accel_sum > cfg.accel_limit_sq));

	assign item_valid = valid_s1;
	assign item_data  = {now_s1, motion, at_target_s1};

endmodule

// File: design/tss_back.sv
module tss_back
	import tss_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tss_cfg_t             cfg,
	input  logic                 item_valid,
	input  logic [TIME_BITS+1:0] item_data,
	output logic                 item_pop,
	input  logic                 res_ready,
	output logic                 res_valid,
	output tss_result_t          res
);

	tss_mode_t            mode_q, mode_d;
	logic [TIME_BITS-1:0] last_motion_q, last_motion_d;
	logic [TIME_BITS-1:0] phase_start_q, phase_start_d;
	logic [TIME_BITS-1:0] last_report_q, last_report_d;
	logic                 sweep_up_q, sweep_up_d;
	logic signed [10:0]   goal_q, goal_d;
	logic                 pin_q, pin_d;

	logic [TIME_BITS-1:0] now;
	logic                 motion;
	logic                 at_target;
	logic                 step;
	logic [TIME_BITS-1:0] d_quiet, d_phase, d_report;
	logic                 quiet_short;
	logic                 settle_done;
	logic                 scan_done;
	logic                 run;
	logic                 due;
	logic signed [10:0]   limit_pos;

	assign now       = item_data[TIME_BITS+1:2];
	assign motion    = item_data[1];
	assign at_target = item_data[0];
	assign step      = item_valid && res_ready;
	assign item_pop  = step;
	assign res_valid = step;
	assign limit_pos = $signed({1'b0, cfg.tilt_limit_steps});

	// wrapping time differences
	assign d_quiet     = now - last_motion_d;
	assign d_phase     = now - phase_start_q;
	assign d_report    = now - last_report_q;
	assign quiet_short = 64'(d_quiet) < 64'(cfg.quiet_ms);
	assign settle_done = 64'(d_phase) >= 64'(cfg.settle_ms);
	assign scan_done   = 64'(d_phase) >= 64'(cfg.scan_ms);

	always_comb begin
		mode_d        = mode_q;
		last_motion_d = motion ? now : last_motion_q;
		phase_start_d = phase_start_q;
		sweep_up_d    = sweep_up_q;
		goal_d        = goal_q;
		pin_d         = pin_q;
		run           = 1'b0;
		case (mode_q)
			MODE_MOVING: begin
				if (!quiet_short) begin
					mode_d        = MODE_STAB;
					phase_start_d = now;
				end
				pin_d  = at_target;
				goal_d = '0;
				run    = 1'b1;
			end
			MODE_STAB: begin
				if (quiet_short) begin
					mode_d = MODE_MOVING;
				end else begin
					if (settle_done) begin
						mode_d        = MODE_SCAN;
						phase_start_d = now;
						sweep_up_d    = 1'b1;
						pin_d         = 1'b0;
					end
					goal_d = '0;
					run    = 1'b1;
				end
			end
			MODE_SCAN: begin
				if (quiet_short) begin
					mode_d = MODE_MOVING;
				end else if (scan_done) begin
					mode_d = MODE_DONE;
					goal_d = '0;
				end else begin
					pin_d = 1'b0;
					if (at_target) begin
						sweep_up_d = !sweep_up_q;
						goal_d     = sweep_up_q ? -limit_pos : limit_pos;
					end
					run = 1'b1;
				end
			end
			MODE_DONE: begin
				if (quiet_short) begin
					mode_d = MODE_MOVING;
				end else begin
					pin_d  = at_target;
					goal_d = '0;
					run    = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_MOVING;
			end
		endcase

		due           = 64'(d_report) >= 64'(cfg.report_ms);
		last_report_d = due ? now : last_report_q;

		res.scan_state     = mode_d;
		res.target_steps   = goal_d;
		res.step_run       = run;
		res.driver_disable = pin_d;
		res.base_moving    = (mode_d == MODE_MOVING) || (mode_d == MODE_STAB);
		res.report_due     = due;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_MOVING;
			last_motion_q <= '0;
			phase_start_q <= '0;
			last_report_q <= '0;
			sweep_up_q    <= 1'b1;
			goal_q        <= '0;
			pin_q         <= 1'b0;
		end else if (step) begin
			mode_q        <= mode_d;
			last_motion_q <= last_motion_d;
			phase_start_q <= phase_start_d;
			last_report_q <= last_report_d;
			sweep_up_q    <= sweep_up_d;
			goal_q        <= goal_d;
			pin_q         <= pin_d;
		end
	end

endmodule

// File: design/tilt_scan_sequencer.sv
// tilt scan sequencer: takes one control pass per beat (timestamp, gyro and
// acceleration vectors, stepper at-target flag) and returns one result beat
// per pass with the sequencer state, step target, run request, driver pin
// level, moving flag and report pulse. Motion is flagged, when an IMU is
// marked present, if the sum of squares of either vector is strictly above
// its squared limit. A new pass is taken every cycle while the front is not
// full; the sustained rate of one beat per cycle is set by the back-end state
// update. A pushed pass is held in the front square register, then written
// to the classified-pass queue, then stepped by the back end into the result
// queue, from which it can be popped; a full queue holds it back. The two
// queues let the front keep taking passes while results wait to be popped.
// Registers are written through the plain write port and should only change
// while no pass is in flight.
module tilt_scan_sequencer
	import tss_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	// pass input queue side
	input  logic                   push,
	output logic                   full,
	input  logic [31:0]            now_ms,
	input  logic signed [15:0]     gyro_x,
	input  logic signed [15:0]     gyro_y,
	input  logic signed [15:0]     gyro_z,
	input  logic signed [15:0]     accel_x,
	input  logic signed [15:0]     accel_y,
	input  logic signed [15:0]     accel_z,
	input  logic                   at_target,

	// result queue side
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             scan_state,
	output logic signed [10:0]     target_steps,
	output logic                   step_run,
	output logic                   driver_disable,
	output logic                   base_moving,
	output logic                   report_due
);

	localparam int ITEM_W = TIME_BITS + 2;

	tss_cfg_t          cfg_q;

	// front to queue
	logic              fr_valid;
	logic              fr_ready;
	logic [ITEM_W-1:0] fr_data;
	logic              mid_full;

	// queue to back end
	logic              mid_empty;
	logic [ITEM_W-1:0] mid_data;
	logic              bk_pop;

	// back end to result queue
	logic              res_valid;
	tss_result_t       res;
	logic              out_full;
	logic [RESULT_W-1:0] out_data;
	tss_result_t       out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.imu_present      <= 1'b1;
			cfg_q.gyro_limit_sq    <= 32'd6400;
			cfg_q.accel_limit_sq   <= 32'd6400;
			cfg_q.quiet_ms         <= 16'd1000;
			cfg_q.settle_ms        <= 16'd1000;
			cfg_q.scan_ms          <= 32'd30000;
			cfg_q.tilt_limit_steps <= 10'd200;
			cfg_q.report_ms        <= 16'd20;
		end else if (cfg_we) begin
			case (tss_reg_t'(cfg_index))
				REG_IMU_PRESENT:    cfg_q.imu_present      <= cfg_data[0];
				REG_GYRO_LIMIT_SQ:  cfg_q.gyro_limit_sq    <= cfg_data;
				REG_ACCEL_LIMIT_SQ: cfg_q.accel_limit_sq   <= cfg_data;
				REG_QUIET_MS:       cfg_q.quiet_ms         <= cfg_data[15:0];
				REG_SETTLE_MS:      cfg_q.settle_ms        <= cfg_data[15:0];
				REG_SCAN_MS:        cfg_q.scan_ms          <= cfg_data;
				REG_TILT_LIMIT:     cfg_q.tilt_limit_steps <= cfg_data[9:0];
				REG_REPORT_MS:      cfg_q.report_ms        <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// front: squares the vectors and flags motion
	tss_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.now_ms     (now_ms),
		.gyro_x     (gyro_x),
		.gyro_y     (gyro_y),
		.gyro_z     (gyro_z),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.at_target  (at_target),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item_data  (fr_data)
	);

	assign fr_ready = !mid_full;

	// short queue of classified passes between front and back
	tss_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (4)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid && !mid_full),
		.wr_data (fr_data),
		.full    (mid_full),
		.rd_en   (bk_pop),
		.rd_data (mid_data),
		.empty   (mid_empty)
	);

	// back end: sequencer state machine, one pass per cycle while a pass waits and the result queue has room
	tss_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (!mid_empty),
		.item_data  (mid_data),
		.item_pop   (bk_pop),
		.res_ready  (!out_full),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result queue, parts the back end from the consumer
	tss_fifo #(
		.WIDTH (RESULT_W),
		.DEPTH (2)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (out_full),
		.rd_en   (pop && !empty),
		.rd_data (out_data),
		.empty   (empty)
	);

	assign out_res        = out_data;
	assign scan_state     = out_res.scan_state;
	assign target_steps   = out_res.target_steps;
	assign step_run       = out_res.step_run;
	assign driver_disable = out_res.driver_disable;
	assign base_moving    = out_res.base_moving;
	assign report_due     = out_res.report_due;

endmodule
